>>> hdl/acfp_pkg.sv
package acfp_pkg;

    // Parser phases.
    localparam logic [1:0] PHASE_WAIT  = 2'd0;
    localparam logic [1:0] PHASE_TENS  = 2'd1;
    localparam logic [1:0] PHASE_UNITS = 2'd2;
    localparam logic [1:0] PHASE_TERM  = 2'd3;

    // Frame characters.
    localparam logic [7:0] CHAR_SET   = 8'h3D; // '='
    localparam logic [7:0] CHAR_UP    = 8'h2B; // '+'
    localparam logic [7:0] CHAR_DOWN  = 8'h2D; // '-'
    localparam logic [7:0] CHAR_POWER = 8'h50; // 'P'
    localparam logic [7:0] CHAR_MUTE  = 8'h4D; // 'M'
    localparam logic [7:0] CHAR_TERM  = 8'h3B; // ';'
    localparam logic [7:0] CHAR_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39; // '9'

    // Command codes.
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_SET   = 3'd1;
    localparam logic [2:0] CMD_UP    = 3'd2;
    localparam logic [2:0] CMD_DOWN  = 3'd3;
    localparam logic [2:0] CMD_POWER = 3'd4;
    localparam logic [2:0] CMD_MUTE  = 3'd5;

    typedef struct packed {
        logic [1:0] phase;
        logic [2:0] command;
        logic [6:0] value;
    } t_parse_state;

    typedef struct packed {
        logic       valid;
        logic [2:0] command_code;
        logic [6:0] frame_value;
    } t_frame_result;

endpackage

>>> hdl/acfp_step.sv
module acfp_step (
    input  acfp_pkg::t_parse_state  i_state,
    input  logic [7:0]              i_byte,
    output acfp_pkg::t_parse_state  o_state,
    output acfp_pkg::t_frame_result o_result
);

    logic [2:0] cmd_code;
    logic       is_digit;
    logic [6:0] digit;

    always_comb begin
        unique case (i_byte)
            acfp_pkg::CHAR_SET:   cmd_code = acfp_pkg::CMD_SET;
            acfp_pkg::CHAR_UP:    cmd_code = acfp_pkg::CMD_UP;
            acfp_pkg::CHAR_DOWN:  cmd_code = acfp_pkg::CMD_DOWN;
            acfp_pkg::CHAR_POWER: cmd_code = acfp_pkg::CMD_POWER;
            acfp_pkg::CHAR_MUTE:  cmd_code = acfp_pkg::CMD_MUTE;
            default:              cmd_code = acfp_pkg::CMD_NONE;
        endcase
    end

    assign is_digit = (i_byte >= acfp_pkg::CHAR_ZERO) && (i_byte <= acfp_pkg::CHAR_NINE);
    assign digit    = {3'd0, i_byte[3:0]};

    always_comb begin
        o_state               = i_state;
        o_result.valid        = 1'b0;
        o_result.command_code = i_state.command;
        o_result.frame_value  = i_state.value;
        unique case (i_state.phase)
            acfp_pkg::PHASE_WAIT: begin
                if (cmd_code != acfp_pkg::CMD_NONE) begin
                    o_state.command = cmd_code;
                    o_state.phase   = acfp_pkg::PHASE_TENS;
                end
            end
            acfp_pkg::PHASE_TENS: begin
                if (is_digit) begin
                    // Times ten as two shifted copies.
                    o_state.value = (digit << 3) + (digit << 1);
                    o_state.phase = acfp_pkg::PHASE_UNITS;
                end else begin
                    o_state.phase = acfp_pkg::PHASE_WAIT;
                end
            end
            acfp_pkg::PHASE_UNITS: begin
                if (is_digit) begin
                    o_state.value = i_state.value + digit;
                    o_state.phase = acfp_pkg::PHASE_TERM;
                end else begin
                    o_state.phase = acfp_pkg::PHASE_WAIT;
                end
            end
            default: begin
                o_result.valid = (i_byte == acfp_pkg::CHAR_TERM);
                o_state.phase  = acfp_pkg::PHASE_WAIT;
            end
        endcase
    end

endmodule

>>> hdl/ascii_command_frame_parser.sv
// Channel   Direction  Handshake            Payload
// rx        in         i_valid / o_stall    i_rx_byte[7:0]
// frame     out        o_valid / i_stall    o_command_code[2:0], o_frame_value[6:0]
//
// A byte beat is taken into an input register, parsed from there, and a
// completed frame lands in the output register.
// One byte per cycle is sustained while the output register is not stalled;
// the parser state updates once per byte. Reset returns the parser to waiting
// for a command and empties both registers. When the output register is full
// and stalled, the input register holds and o_stall rises, so at most one byte waits behind a pending result.
module ascii_command_frame_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_command_code,
    output logic [6:0] o_frame_value
);

    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_out_valid;
    logic [2:0]              r_out_code;
    logic [6:0]              r_out_value;
    acfp_pkg::t_parse_state  r_state;
    acfp_pkg::t_parse_state  n_state;
    acfp_pkg::t_frame_result step_result;
    logic                    out_free;
    logic                    advance;
    logic                    accept;

    acfp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (step_result)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.phase   <= acfp_pkg::PHASE_WAIT;
            r_state.command <= acfp_pkg::CMD_NONE;
            r_state.value   <= 7'd0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= step_result.valid;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance && step_result.valid) begin
            r_out_code  <= step_result.command_code;
            r_out_value <= step_result.frame_value;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_command_code = r_out_code;
    assign o_frame_value  = r_out_value;

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1600;
    localparam int CYCLE_LIMIT  = 200000;

    // Predicts the frames that a stream of accepted bytes produces and
    // checks each delivered frame against the oldest prediction.
    class frame_scoreboard;
        logic [1:0]              phase;
        logic [2:0]              held_command;
        logic [6:0]              value_sum;
        acfp_pkg::t_frame_result expected_frames[$];
        int                      errors;

        function new();
            phase        = acfp_pkg::PHASE_WAIT;
            held_command = acfp_pkg::CMD_NONE;
            value_sum    = '0;
            errors       = 0;
        endfunction

        function logic [2:0] command_of(logic [7:0] rx);
            case (rx)
                acfp_pkg::CHAR_SET:   return acfp_pkg::CMD_SET;
                acfp_pkg::CHAR_UP:    return acfp_pkg::CMD_UP;
                acfp_pkg::CHAR_DOWN:  return acfp_pkg::CMD_DOWN;
                acfp_pkg::CHAR_POWER: return acfp_pkg::CMD_POWER;
                acfp_pkg::CHAR_MUTE:  return acfp_pkg::CMD_MUTE;
                default:              return acfp_pkg::CMD_NONE;
            endcase
        endfunction

        function void note_byte(logic [7:0] rx);
            logic                    is_digit;
            logic [7:0]              digit;
            acfp_pkg::t_frame_result frame;
            is_digit = (rx >= acfp_pkg::CHAR_ZERO) && (rx <= acfp_pkg::CHAR_NINE);
            digit    = rx - acfp_pkg::CHAR_ZERO;
            case (phase)
                acfp_pkg::PHASE_WAIT: begin
                    if (command_of(rx) != acfp_pkg::CMD_NONE) begin
                        held_command = command_of(rx);
                        phase        = acfp_pkg::PHASE_TENS;
                    end
                end
                acfp_pkg::PHASE_TENS: begin
                    if (is_digit) begin
                        value_sum = 7'(digit * 10);
                        phase     = acfp_pkg::PHASE_UNITS;
                    end else begin
                        phase = acfp_pkg::PHASE_WAIT;
                    end
                end
                acfp_pkg::PHASE_UNITS: begin
                    if (is_digit) begin
                        value_sum = 7'(value_sum + digit);
                        phase     = acfp_pkg::PHASE_TERM;
                    end else begin
                        phase = acfp_pkg::PHASE_WAIT;
                    end
                end
                default: begin
                    // Any byte closes the frame, but only the terminator reports it.
                    if (rx == acfp_pkg::CHAR_TERM) begin
                        frame.valid        = 1'b1;
                        frame.command_code = held_command;
                        frame.frame_value  = value_sum;
                        expected_frames.push_back(frame);
                    end
                    phase = acfp_pkg::PHASE_WAIT;
                end
            endcase
        endfunction

        function void check_frame(logic [2:0] code, logic [6:0] value);
            acfp_pkg::t_frame_result frame;
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected frame, code %0d value %0d", $time, code, value);
                errors++;
                return;
            end
            frame = expected_frames.pop_front();
            if (code !== frame.command_code) begin
                $display("%0t: command_code expected %0d actual %0d",
                         $time, frame.command_code, code);
                errors++;
            end
            if (value !== frame.frame_value) begin
                $display("%0t: frame_value expected %0d actual %0d",
                         $time, frame.frame_value, value);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = '0;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_command_code;
    logic [6:0] o_frame_value;

    frame_scoreboard frames;
    int              bytes_sent = 0;
    int              cycles     = 0;
    bit              send_calm  = 0;
    bit              take_calm  = 0;

    ascii_command_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_command_code (o_command_code),
        .o_frame_value  (o_frame_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d frames outstanding",
                     $time, frames.expected_frames.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Frame beats are taken at the edge where o_valid is high and i_stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            frames.check_frame(o_command_code, o_frame_value);
        end
    end

    task automatic send_byte(input logic [7:0] rx);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (o_stall);
        frames.note_byte(rx);
        bytes_sent++;
        if ($urandom_range(0, 29) == 0) begin
            send_calm = !send_calm;
        end
    endtask

    task automatic send_text(input string text);
        for (int k = 0; k < text.len(); k++) begin
            send_byte(text[k]);
        end
    endtask

    task automatic drain_frames();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (frames.expected_frames.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_command_char();
        case ($urandom_range(0, 4))
            0:       return acfp_pkg::CHAR_SET;
            1:       return acfp_pkg::CHAR_UP;
            2:       return acfp_pkg::CHAR_DOWN;
            3:       return acfp_pkg::CHAR_POWER;
            default: return acfp_pkg::CHAR_MUTE;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit_char();
        return acfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Receiver: holds off a random number of cycles before each frame beat.
    initial begin
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = take_calm ? 0 : $urandom_range(0, 6);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            if ($urandom_range(0, 19) == 0) begin
                take_calm = !take_calm;
            end
        end
    end

    initial begin
        logic [7:0] frame_bytes [4];
        int         kind;
        int         spot;
        bit         paused;
        frames = new();
        paused = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bytes outside any frame, both value extremes, bad digits on either
        // side of the digit range, a command char in the terminator slot.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("=00;");
        send_text("+99;");
        send_text("-/");
        send_text("P9:");
        send_text("M47P");
        send_text("=+");
        send_text("-38;");

        while (bytes_sent < RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            frame_bytes[0] = pick_command_char();
            frame_bytes[1] = pick_digit_char();
            frame_bytes[2] = pick_digit_char();
            frame_bytes[3] = acfp_pkg::CHAR_TERM;
            if (kind < 70) begin
                foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
            end else if (kind < 85) begin
                spot = $urandom_range(1, 3);
                frame_bytes[spot] = 8'($urandom_range(0, 255));
                for (int k = 0; k < 4; k++) begin
                    send_byte(frame_bytes[k]);
                end
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            if (!paused && bytes_sent > RANDOM_BYTES / 2) begin
                paused = 1;
                drain_frames();
            end
        end

        drain_frames();
        repeat (10) @(posedge i_clk);
        if (frames.expected_frames.size() != 0) begin
            $display("%0t: %0d frames never arrived", $time, frames.expected_frames.size());
        end
        if (frames.errors == 0 && frames.expected_frames.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> ascii_command_frame_parser.f
hdl/acfp_pkg.sv
hdl/acfp_step.sv
hdl/ascii_command_frame_parser.sv
tb/testbench.sv
